>>> design/pdc_pkg.sv
// shared types, constants and letter helpers for the playfair digraph cipher
// used by pdc_ctrl, pdc_datapath and playfair_digraph_cipher_top
package pdc_pkg;

    localparam int LETTER_W     = 5;
    localparam int ALPHA_N      = 26;
    localparam int SIDE         = 5;
    localparam int CELLS        = SIDE * SIDE;
    localparam int RC_W         = 3;

    localparam logic [LETTER_W-1:0] LETTER_I     = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J     = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_Z     = 5'd25;
    localparam logic [LETTER_W-1:0] FILLER_RESET = 5'd23;

    localparam logic FUNC_KEY   = 1'b0;
    localparam logic FUNC_PLAIN = 1'b1;

    typedef struct packed {
        logic accept;
        logic fill_step;
        logic pair_step;
        logic pos_read;
        logic sq_read;
        logic out_second;
    } dp_cmd_t;

    typedef struct packed {
        logic key_complete;
        logic fill_done;
        logic item_func;
        logic pair_go;
    } dp_status_t;

    typedef struct packed {
        logic [RC_W-1:0] row;
        logic [RC_W-1:0] col;
    } rc_t;

    // out-of-range codes act as Z, J acts as I
    function automatic logic [LETTER_W-1:0] plain_code(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] c;
        c = (v > LETTER_Z) ? LETTER_Z : v;
        return (c == LETTER_J) ? LETTER_I : c;
    endfunction

    // cell index to row and column without a divider
    function automatic rc_t cell_rc(input logic [LETTER_W-1:0] idx);
        rc_t r;
        logic [LETTER_W-1:0] base;
        if (idx >= 5'(4 * SIDE))
            r.row = 3'd4;
        else if (idx >= 5'(3 * SIDE))
            r.row = 3'd3;
        else if (idx >= 5'(2 * SIDE))
            r.row = 3'd2;
        else if (idx >= 5'(SIDE))
            r.row = 3'd1;
        else
            r.row = 3'd0;
        base  = 5'(r.row) * 5'(SIDE);
        r.col = 3'(idx - base);
        return r;
    endfunction

    function automatic logic [RC_W-1:0] rc_inc(input logic [RC_W-1:0] v);
        return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [LETTER_W-1:0] rc_addr(input logic [RC_W-1:0] row,
                                                     input logic [RC_W-1:0] col);
        return 5'(row) * 5'(SIDE) + 5'(col);
    endfunction

endpackage

>>> design/pdc_ctrl.sv
// controller state machine for the playfair digraph cipher
// depends on pdc_pkg; drives pdc_datapath through dp_cmd_t
module pdc_ctrl
    import pdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_func,
    input  logic       s_last,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FILL   = 7'b0000010,
        ST_PAIR   = 7'b0000100,
        ST_LOOKUP = 7'b0001000,
        ST_MAP    = 7'b0010000,
        ST_OUT0   = 7'b0100000,
        ST_OUT1   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_FILL;   // loads the plain alphabet after reset
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    if (s_func == FUNC_KEY)
                        state_next = s_last ? ST_FILL : ST_IDLE;
                    else
                        state_next = status.key_complete ? ST_PAIR : ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_done)
                    state_next = (status.item_func == FUNC_PLAIN) ? ST_PAIR : ST_IDLE;
            end
            ST_PAIR:
            begin
                cmd.pair_step = 1'b1;
                state_next    = status.pair_go ? ST_LOOKUP : ST_IDLE;
            end
            ST_LOOKUP:
            begin
                cmd.pos_read = 1'b1;
                state_next   = ST_MAP;
            end
            ST_MAP:
            begin
                cmd.sq_read = 1'b1;
                state_next  = ST_OUT0;
            end
            ST_OUT0:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                    state_next = ST_OUT1;
            end
            ST_OUT1:
            begin
                m_tvalid       = 1'b1;
                cmd.out_second = 1'b1;
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_out_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> status.key_complete)
        else $error("result presented while the square is incomplete");

    a_fill_to_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && status.fill_done && status.item_func == FUNC_PLAIN)
        |=> state_reg == ST_PAIR)
        else $error("pending plaintext lost after square fill");

    a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT0 && m_tready) |=> (m_tvalid && cmd.out_second))
        else $error("second cipher letter of the pair missing");

endmodule

>>> design/pdc_datapath.sv
// datapath: key square, letter position table, pairing and digraph mapping
// depends on pdc_pkg; controlled by pdc_ctrl through dp_cmd_t
module pdc_datapath
    import pdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LETTER_W-1:0] cfg_wdata,
    input  logic                in_func,
    input  logic [LETTER_W-1:0] in_letter,
    input  logic                in_last,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output logic [LETTER_W-1:0] out_letter
);

    // square cells and the inverse table letter -> cell
    logic [LETTER_W-1:0] square_mem [CELLS];
    logic [LETTER_W-1:0] pos_mem    [ALPHA_N];

    logic [ALPHA_N-1:0]  used_reg, used_next;
    logic [LETTER_W-1:0] fc_reg, fc_next;
    logic                key_complete_reg, key_complete_next;
    logic                held_valid_reg, held_valid_next;
    logic [LETTER_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic                item_func_reg;
    logic                item_last_reg;
    logic [LETTER_W-1:0] filler_reg;

    logic [LETTER_W-1:0] item_letter_reg;
    logic [LETTER_W-1:0] held_letter_reg, held_letter_next;
    logic [LETTER_W-1:0] pair_a_reg, pair_a_next;
    logic [LETTER_W-1:0] pair_b_reg, pair_b_next;
    logic [LETTER_W-1:0] pos_a_reg, pos_b_reg;
    logic [LETTER_W-1:0] sq_a_reg, sq_b_reg;

    logic                wr_en;
    logic [LETTER_W-1:0] wr_letter;
    logic [LETTER_W-1:0] wr_idx;

    logic [31:0]         used_ext;
    logic [31:0]         used_eff_ext;
    logic [LETTER_W-1:0] fc_eff;
    logic [LETTER_W-1:0] p_code, f_code;
    rc_t                 rc_a, rc_b, map_a, map_b;
    logic [LETTER_W-1:0] addr_a, addr_b;

    assign used_ext = {6'd0, used_reg};
    assign p_code   = plain_code(item_letter_reg);
    assign f_code   = plain_code(filler_reg);

    always_comb
    begin
        used_next         = used_reg;
        fc_next           = fc_reg;
        key_complete_next = key_complete_reg;
        held_valid_next   = held_valid_reg;
        held_letter_next  = held_letter_reg;
        fill_cnt_next     = fill_cnt_reg;
        pair_a_next       = pair_a_reg;
        pair_b_next       = pair_b_reg;
        wr_en             = 1'b0;
        wr_letter         = in_letter;
        wr_idx            = fc_reg;
        used_eff_ext      = used_ext;
        fc_eff            = fc_reg;

        if (cmd.accept)
        begin
            fill_cnt_next = '0;
            if (in_func == FUNC_KEY)
            begin
                // a key letter after a finished key starts a new one
                if (key_complete_reg)
                begin
                    used_eff_ext    = '0;
                    fc_eff          = '0;
                    held_valid_next = 1'b0;
                end
                wr_idx    = fc_eff;
                wr_letter = in_letter;
                wr_en     = (in_letter <= LETTER_Z) && (in_letter != LETTER_J) &&
                            !used_eff_ext[in_letter] && (fc_eff < 5'(CELLS));
                used_next         = used_eff_ext[ALPHA_N-1:0];
                fc_next           = fc_eff;
                key_complete_next = 1'b0;
                if (wr_en)
                begin
                    used_next[in_letter] = 1'b1;
                    fc_next              = fc_eff + 5'd1;
                end
            end
        end

        if (cmd.fill_step)
        begin
            wr_idx        = fc_reg;
            wr_letter     = fill_cnt_reg;
            wr_en         = (fill_cnt_reg != LETTER_J) && !used_ext[fill_cnt_reg] &&
                            (fc_reg < 5'(CELLS));
            fill_cnt_next = fill_cnt_reg + 5'd1;
            if (wr_en)
            begin
                used_next[fill_cnt_reg] = 1'b1;
                fc_next                 = fc_reg + 5'd1;
            end
            if (fill_cnt_reg == LETTER_Z)
                key_complete_next = 1'b1;
        end

        if (cmd.pair_step)
        begin
            if (!held_valid_reg)
            begin
                if (!item_last_reg)
                begin
                    held_letter_next = p_code;
                    held_valid_next  = 1'b1;
                end
                else
                begin
                    pair_a_next = p_code;
                    pair_b_next = f_code;
                end
            end
            else
            begin
                held_valid_next = 1'b0;
                pair_a_next     = held_letter_reg;
                pair_b_next     = (p_code == held_letter_reg) ? f_code : p_code;
            end
        end
    end

    // digraph rules on the looked-up cells
    always_comb
    begin
        rc_a  = cell_rc(pos_a_reg);
        rc_b  = cell_rc(pos_b_reg);
        map_a = rc_a;
        map_b = rc_b;
        if (rc_a.row == rc_b.row)
        begin
            map_a.col = rc_inc(rc_a.col);
            map_b.col = rc_inc(rc_b.col);
        end
        else if (rc_a.col == rc_b.col)
        begin
            map_a.row = rc_inc(rc_a.row);
            map_b.row = rc_inc(rc_b.row);
        end
        else
        begin
            map_a.col = rc_b.col;
            map_b.col = rc_a.col;
        end
        addr_a = rc_addr(map_a.row, map_a.col);
        addr_b = rc_addr(map_b.row, map_b.col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg         <= '0;
            fc_reg           <= '0;
            key_complete_reg <= 1'b0;
            held_valid_reg   <= 1'b0;
            fill_cnt_reg     <= '0;
            item_func_reg    <= FUNC_KEY;
            item_last_reg    <= 1'b0;
            filler_reg       <= FILLER_RESET;
        end
        else
        begin
            used_reg         <= used_next;
            fc_reg           <= fc_next;
            key_complete_reg <= key_complete_next;
            held_valid_reg   <= held_valid_next;
            fill_cnt_reg     <= fill_cnt_next;
            if (cmd.accept)
            begin
                item_func_reg <= in_func;
                item_last_reg <= in_last;
            end
            if (cfg_we)
                filler_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_letter_reg <= in_letter;
        held_letter_reg <= held_letter_next;
        pair_a_reg      <= pair_a_next;
        pair_b_reg      <= pair_b_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            square_mem[wr_idx] <= wr_letter;
            pos_mem[wr_letter] <= wr_idx;
        end
        if (cmd.pos_read)
        begin
            pos_a_reg <= pos_mem[pair_a_reg];
            pos_b_reg <= pos_mem[pair_b_reg];
        end
        if (cmd.sq_read)
        begin
            sq_a_reg <= square_mem[addr_a];
            sq_b_reg <= square_mem[addr_b];
        end
    end

    assign out_letter          = cmd.out_second ? sq_b_reg : sq_a_reg;
    assign status.key_complete = key_complete_reg;
    assign status.fill_done    = (fill_cnt_reg == LETTER_Z);
    assign status.item_func    = item_func_reg;
    assign status.pair_go      = held_valid_reg || item_last_reg;

    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= 5'(CELLS))
        else $error("square fill count past the last cell");

    a_fill_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fill_step && fill_cnt_reg == LETTER_Z) |=> (key_complete_reg && fc_reg == 5'(CELLS)))
        else $error("square not full after fill walk");

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !cmd.accept) |-> !used_ext[wr_letter])
        else $error("letter placed twice in the square");

endmodule

>>> design/playfair_digraph_cipher_top.sv
// playfair digraph encryption: after reset a fill walk loads the plain alphabet
// square, with s_tready low; the filler register resets to X
// a key letter marked last is followed by the fill walk
// a plaintext letter that completes a pair gives its first cipher letter after the
// PAIR, LOOKUP and MAP states and the second after m_tready takes the first
// one item at a time; plaintext arriving on an unfinished key waits for the fill walk
module playfair_digraph_cipher_top
    import pdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LETTER_W-1:0] cfg_wdata,    // filler_letter
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,      // [4:0] letter, [7:5] zero
    input  logic                s_tuser,      // [0] func
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,      // [4:0] cipher_letter, [7:5] zero
    output logic                m_tlast       // pair_end
);

    dp_cmd_t             cmd;
    dp_status_t          status;
    logic [LETTER_W-1:0] out_letter;

    pdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .s_last   (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pdc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_func    (s_tuser),
        .in_letter  (s_tdata[LETTER_W-1:0]),
        .in_last    (s_tlast),
        .cmd        (cmd),
        .status     (status),
        .out_letter (out_letter)
    );

    assign m_tdata = {3'd0, out_letter};
    assign m_tlast = cmd.out_second;

endmodule
